@@ rtl/hbtm_pkg.sv @@
`default_nettype none

package hbtm_pkg;

  localparam int unsigned SLOTS    = 16;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned NAME_MAX = 32;
  localparam int unsigned AGE_W    = 32;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned VER_W    = 8;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [AGE_W-1:0] AGE_MAX       = '1;
  localparam logic [AGE_W-1:0] TIMEOUT_RESET = AGE_W'(1000);
  localparam logic [VER_W-1:0] VERSION_RESET = VER_W'(1);

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_MASK    = 2'd1;
  localparam logic [1:0] REG_MAGIC   = 2'd2;
  localparam logic [1:0] REG_VERSION = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_REPORT = 2'd1,
    OP_RESET  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_ALIVE     = 2'd0,
    KIND_TIMEOUT   = 2'd1,
    KIND_RESET_OK  = 2'd2,
    KIND_RESET_BAD = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FLUSH
  } state_e;

endpackage

`default_nettype wire

@@ rtl/heartbeat_timeout_monitor_unit.sv @@
`default_nettype none

// Heartbeat watchdog over 16 service slots. A tick word walks the slots with one shared
// saturating age incrementer and timeout comparator, one slot per cycle unless a timeout
// waits on a stalled output: idle accepts the word, the scan state walks the 16 slots and
// the flush state releases the last event. Report and reset words pass the exec state and
// wait there while an event waits on the output. in_ready_o is high only when no word is in
// progress. Timeout events leave in ascending slot order, and last_o marks the final event
// of a word; a tick with no timeout and an invalid report give no event. Registers sit on a
// 32-bit APB port at byte addresses 0x0 timeout, 0x4 watched mask, 0x8 magic, 0xC version.
module heartbeat_timeout_monitor_unit
  import hbtm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [SLOT_W-1:0]  slot_i,
  input  wire logic [31:0]        magic_i,
  input  wire logic [7:0]         version_i,
  input  wire logic [7:0]         name_length_i,
  input  wire logic               size_ok_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [SLOT_W-1:0]       event_slot_o,
  output logic [1:0]              event_kind_o,
  output logic                    last_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  state_e state_q, state_d;

  logic [AGE_W-1:0]  timeout_q;
  logic [MASK_W-1:0] mask_q;
  logic [31:0]       exp_magic_q;
  logic [VER_W-1:0]  exp_ver_q;

  logic              learned_q [SLOTS];
  logic              alive_q   [SLOTS];
  logic [AGE_W-1:0]  age_q     [SLOTS];

  logic [1:0]        op_q;
  logic [SLOT_W-1:0] slot_q;
  logic [31:0]       magic_q;
  logic [7:0]        ver_q;
  logic [7:0]        nlen_q;
  logic              size_q;

  logic [SLOT_W-1:0] idx_q;
  logic              pend_valid_q;
  logic [SLOT_W-1:0] pend_slot_q;

  logic              out_valid_q;
  logic [SLOT_W-1:0] out_slot_q;
  kind_e             out_kind_q;
  logic              out_last_q;

  logic              cfg_we;
  logic              in_acc;
  logic              out_free;
  logic              scan_last;
  logic              scan_watched;
  logic [AGE_W-1:0]  scan_age_inc;
  logic              scan_hit;
  logic              scan_stall;
  logic              slot_in_range;
  logic              slot_watched;
  logic              report_ok;
  logic              exec_emit;
  logic              exec_go;

  logic              push;
  logic [SLOT_W-1:0] push_slot;
  kind_e             push_kind;
  logic              push_last;
  logic              pend_set;
  logic              pend_clr;

  logic              wr_en;
  logic [SLOT_W-1:0] wr_idx;
  logic              age_we;
  logic [AGE_W-1:0]  age_wdata;
  logic              alive_we;
  logic              alive_wdata;
  logic              learned_we;

  assign cfg_we   = psel & penable & pwrite;
  assign pready   = 1'b1;
  assign in_acc   = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_TIMEOUT: prdata = timeout_q;
      REG_MASK:    prdata = PDATA_W'(mask_q);
      REG_MAGIC:   prdata = exp_magic_q;
      REG_VERSION: prdata = PDATA_W'(exp_ver_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TIMEOUT_RESET;
      mask_q      <= '0;
      exp_magic_q <= '0;
      exp_ver_q   <= VERSION_RESET;
    end else if (cfg_we) begin
      case (paddr[PADDR_W-1:2])
        REG_TIMEOUT: timeout_q   <= pwdata[AGE_W-1:0];
        REG_MASK:    mask_q      <= pwdata[MASK_W-1:0];
        REG_MAGIC:   exp_magic_q <= pwdata[31:0];
        REG_VERSION: exp_ver_q   <= pwdata[VER_W-1:0];
        default: ;
      endcase
    end
  end

  assign scan_last    = (idx_q == SLOT_W'(SLOTS - 1));
  assign scan_watched = mask_q[idx_q] | learned_q[idx_q];
  assign scan_age_inc = (age_q[idx_q] == AGE_MAX) ? AGE_MAX : age_q[idx_q] + AGE_W'(1);
  assign scan_hit     = scan_age_inc >= timeout_q;
  assign scan_stall   = (state_q == ST_SCAN) & scan_watched & scan_hit & pend_valid_q
                        & ~out_free;

  assign slot_in_range = (32'(slot_q) < SLOTS);
  assign slot_watched  = slot_in_range & (mask_q[slot_q] | learned_q[slot_q]);
  assign report_ok     = size_q & (magic_q == exp_magic_q) & (ver_q == exp_ver_q)
                         & (nlen_q >= 8'd1) & (32'(nlen_q) <= NAME_MAX) & slot_in_range;

  always_comb begin
    case (op_q)
      OP_REPORT: exec_emit = report_ok & ~alive_q[slot_q];
      OP_RESET:  exec_emit = 1'b1;
      default:   exec_emit = 1'b0;
    endcase
  end
  assign exec_go = ~exec_emit | out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (operation_i == OP_TICK) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!scan_stall && scan_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    push        = 1'b0;
    push_slot   = slot_q;
    push_kind   = KIND_ALIVE;
    push_last   = 1'b1;
    pend_set    = 1'b0;
    pend_clr    = 1'b0;
    wr_en       = 1'b0;
    wr_idx      = slot_q;
    age_we      = 1'b0;
    age_wdata   = '0;
    alive_we    = 1'b0;
    alive_wdata = 1'b0;
    learned_we  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_EXEC: begin
        if (exec_go) begin
          case (op_q)
            OP_REPORT: begin
              if (report_ok) begin
                wr_en       = 1'b1;
                age_we      = 1'b1;
                alive_we    = 1'b1;
                alive_wdata = 1'b1;
                learned_we  = 1'b1;
              end
              push      = exec_emit;
              push_kind = KIND_ALIVE;
            end
            OP_RESET: begin
              wr_en     = slot_watched;
              age_we    = slot_watched;
              alive_we  = slot_watched;
              push      = 1'b1;
              push_kind = slot_watched ? KIND_RESET_OK : KIND_RESET_BAD;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        wr_idx = idx_q;
        if (scan_watched && !scan_stall) begin
          wr_en     = 1'b1;
          age_we    = 1'b1;
          age_wdata = scan_hit ? '0 : scan_age_inc;
          alive_we  = scan_hit;
          if (scan_hit) begin
            pend_set  = 1'b1;
            push      = pend_valid_q;
            push_slot = pend_slot_q;
            push_kind = KIND_TIMEOUT;
            push_last = 1'b0;
          end
        end
      end
      ST_FLUSH: begin
        if (pend_valid_q && out_free) begin
          push      = 1'b1;
          push_slot = pend_slot_q;
          push_kind = KIND_TIMEOUT;
          pend_clr  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        idx_q <= '0;
      end else if (state_q == ST_SCAN && !scan_stall) begin
        idx_q <= idx_q + SLOT_W'(1);
      end
      if (pend_set) begin
        pend_valid_q <= 1'b1;
      end else if (pend_clr) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= operation_i;
      slot_q  <= slot_i;
      magic_q <= magic_i;
      ver_q   <= version_i;
      nlen_q  <= name_length_i;
      size_q  <= size_ok_i;
    end
    if (pend_set) begin
      pend_slot_q <= idx_q;
    end
    if (push) begin
      out_slot_q <= push_slot;
      out_kind_q <= push_kind;
      out_last_q <= push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        learned_q[i] <= 1'b0;
        alive_q[i]   <= 1'b0;
        age_q[i]     <= '0;
      end
    end else if (wr_en) begin
      if (age_we) begin
        age_q[wr_idx] <= age_wdata;
      end
      if (alive_we) begin
        alive_q[wr_idx] <= alive_wdata;
      end
      if (learned_we) begin
        learned_q[wr_idx] <= 1'b1;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_slot_o = out_slot_q;
  assign event_kind_o = out_kind_q;
  assign last_o       = out_last_q;

`ifndef NO_ASSERTIONS
  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("event pushed over a waiting event");

  a_pend_only_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == ST_SCAN || state_q == ST_FLUSH))
    else $error("pending timeout outside a tick");

  a_scan_ends_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && !scan_stall && scan_last) |=> (state_q == ST_FLUSH))
    else $error("scan did not end in flush");

  a_exec_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && state_q == ST_EXEC) |-> push_last)
    else $error("report or reset event without last");

  a_flush_clears_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && state_d == ST_IDLE) |=> !pend_valid_q)
    else $error("pending timeout left after tick");
`endif

endmodule

`default_nettype wire
